// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the segment intersection pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SIT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment intersection assertion failed");
`define SIT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("segment intersection forbidden condition seen");
`else
`define SIT_ASSERT(lbl, clk, rst_n, prop)
`define SIT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== hdl/sit_pkg.sv =====
// Types, widths and helpers for the segment intersection pipeline
`timescale 1ns / 1ps
`default_nettype none
package sit_pkg;

  localparam int FieldW     = 16;
  localparam int CoordWidth = 16;
  localparam int DiffW      = CoordWidth + 1;
  localparam int PrdW       = 2 * DiffW;
  localparam int NumW       = PrdW + 1;

  typedef enum logic [1:0] {
    RelCross     = 2'd0,
    RelParallel  = 2'd1,
    RelCollinear = 2'd2
  } rel_e;

  typedef struct packed {
    logic signed [FieldW-1:0] ax0;
    logic signed [FieldW-1:0] ay0;
    logic signed [FieldW-1:0] ax1;
    logic signed [FieldW-1:0] ay1;
    logic signed [FieldW-1:0] bx0;
    logic signed [FieldW-1:0] by0;
    logic signed [FieldW-1:0] bx1;
    logic signed [FieldW-1:0] by1;
  } sit_in_t;

  typedef struct packed {
    logic hit;
    rel_e relation;
  } sit_out_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dax;
    logic signed [DiffW-1:0] day;
    logic signed [DiffW-1:0] dbx;
    logic signed [DiffW-1:0] dby;
    logic signed [DiffW-1:0] ox;
    logic signed [DiffW-1:0] oy;
    logic                    box_hit;
  } diff_t;

  typedef struct packed {
    logic signed [PrdW-1:0] na_p;
    logic signed [PrdW-1:0] na_q;
    logic signed [PrdW-1:0] nb_p;
    logic signed [PrdW-1:0] nb_q;
    logic signed [PrdW-1:0] d_p;
    logic signed [PrdW-1:0] d_q;
    logic                   box_hit;
  } prod_t;

  typedef struct packed {
    logic signed [NumW-1:0] na;
    logic signed [NumW-1:0] nb;
    logic signed [NumW-1:0] d;
    logic                   box_hit;
  } num_t;

  // take the low CoordWidth bits of a field, top bit is the sign
  function automatic logic signed [CoordWidth-1:0] coord_f(input logic [FieldW-1:0] raw);
    coord_f = signed'(CoordWidth'(raw));
  endfunction

  function automatic logic within_f(input logic signed [CoordWidth-1:0] p,
                                    input logic signed [CoordWidth-1:0] e0,
                                    input logic signed [CoordWidth-1:0] e1);
    within_f = ((p >= e0) && (p <= e1)) || ((p >= e1) && (p <= e0));
  endfunction

  // num/den in [0,1] for a nonzero den
  function automatic logic unit_ratio_f(input logic signed [NumW-1:0] num,
                                        input logic signed [NumW-1:0] den);
    if (den > 0) begin
      unit_ratio_f = (num >= 0) && (num <= den);
    end else begin
      unit_ratio_f = (num <= 0) && (num >= den);
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sit_diff.sv =====
// Stage 1: coordinate differences and collinear extent checks
`timescale 1ns / 1ps
`default_nettype none
module sit_diff (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire sit_pkg::sit_in_t seg_i,
  output logic                 valid_o,
  output sit_pkg::diff_t       diff_o
);
  import sit_pkg::*;

  logic signed [CoordWidth-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  logic   valid_q;
  diff_t  diff_d, diff_q;

  always_comb begin
    x1 = coord_f(seg_i.ax0);
    y1 = coord_f(seg_i.ay0);
    x2 = coord_f(seg_i.ax1);
    y2 = coord_f(seg_i.ay1);
    x3 = coord_f(seg_i.bx0);
    y3 = coord_f(seg_i.by0);
    x4 = coord_f(seg_i.bx1);
    y4 = coord_f(seg_i.by1);

    diff_d.dax = DiffW'(x2) - DiffW'(x1);
    diff_d.day = DiffW'(y2) - DiffW'(y1);
    diff_d.dbx = DiffW'(x4) - DiffW'(x3);
    diff_d.dby = DiffW'(y4) - DiffW'(y3);
    diff_d.ox  = DiffW'(x1) - DiffW'(x3);
    diff_d.oy  = DiffW'(y1) - DiffW'(y3);

    // any endpoint inside the other segment's bounding box
    diff_d.box_hit =
        (within_f(x1, x3, x4) && within_f(y1, y3, y4)) ||
        (within_f(x2, x3, x4) && within_f(y2, y3, y4)) ||
        (within_f(x3, x1, x2) && within_f(y3, y1, y2)) ||
        (within_f(x4, x1, x2) && within_f(y4, y1, y2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

endmodule
`default_nettype wire

// ===== hdl/sit_mult.sv =====
// Stage 2: the six cross-product terms
`timescale 1ns / 1ps
`default_nettype none
module sit_mult (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire sit_pkg::diff_t  diff_i,
  output logic                 valid_o,
  output sit_pkg::prod_t       prod_o
);
  import sit_pkg::*;

  logic   valid_q;
  prod_t  prod_d, prod_q;

  always_comb begin
    prod_d.na_p    = PrdW'(diff_i.dbx) * PrdW'(diff_i.oy);
    prod_d.na_q    = PrdW'(diff_i.dby) * PrdW'(diff_i.ox);
    prod_d.nb_p    = PrdW'(diff_i.dax) * PrdW'(diff_i.oy);
    prod_d.nb_q    = PrdW'(diff_i.day) * PrdW'(diff_i.ox);
    prod_d.d_p     = PrdW'(diff_i.dby) * PrdW'(diff_i.dax);
    prod_d.d_q     = PrdW'(diff_i.dbx) * PrdW'(diff_i.day);
    prod_d.box_hit = diff_i.box_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule
`default_nettype wire

// ===== hdl/sit_combine.sv =====
// Stage 3: numerators and denominator from the product terms
`timescale 1ns / 1ps
`default_nettype none
module sit_combine (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire sit_pkg::prod_t  prod_i,
  output logic                 valid_o,
  output sit_pkg::num_t        num_o
);
  import sit_pkg::*;

  logic  valid_q;
  num_t  num_d, num_q;

  always_comb begin
    num_d.na      = NumW'(prod_i.na_p) - NumW'(prod_i.na_q);
    num_d.nb      = NumW'(prod_i.nb_p) - NumW'(prod_i.nb_q);
    num_d.d       = NumW'(prod_i.d_p) - NumW'(prod_i.d_q);
    num_d.box_hit = prod_i.box_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      num_q <= num_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;

endmodule
`default_nettype wire

// ===== hdl/sit_decide.sv =====
// Stage 4: classify the pair and register the result beat
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sit_decide (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire sit_pkg::num_t   num_i,
  output logic                 valid_o,
  output sit_pkg::sit_out_t    res_o
);
  import sit_pkg::*;

  logic      valid_q;
  sit_out_t  res_d, res_q;
  logic      d_zero, n_zero;

  always_comb begin
    d_zero = (num_i.d == '0);
    n_zero = (num_i.na == '0) && (num_i.nb == '0);
    priority if (d_zero && n_zero) begin
      res_d.relation = RelCollinear;
      res_d.hit      = num_i.box_hit;
    end else if (d_zero) begin
      res_d.relation = RelParallel;
      res_d.hit      = 1'b0;
    end else begin
      res_d.relation = RelCross;
      res_d.hit      = unit_ratio_f(num_i.na, num_i.d) && unit_ratio_f(num_i.nb, num_i.d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  `SIT_NEVER(a_parallel_no_hit, clk_i, rst_ni, valid_q && res_q.hit && (res_q.relation == RelParallel))
  `SIT_ASSERT(a_nonzero_den_cross, clk_i, rst_ni, (valid_i && (num_i.d != '0)) |=> (res_q.relation == RelCross))

endmodule
`default_nettype wire

// ===== hdl/segment_intersection_test.sv =====
// Top level of the segment intersection test pipeline
// Throughput: one segment pair per cycle; four register stages (differences,
// products, numerators, classification), one multiplier row in stage two.
// busy is never raised, and the receiver cannot stall, so no beat waits.
// Reset clears the valid bits of every stage; no result beat is in flight after it.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module segment_intersection_test (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire sit_pkg::sit_in_t seg_i,
  output logic                 busy,
  output logic                 done_o,
  output sit_pkg::sit_out_t    res_o
);
  import sit_pkg::*;

  logic   s1_valid, s2_valid, s3_valid;
  diff_t  s1_diff;
  prod_t  s2_prod;
  num_t   s3_num;
  logic   in_valid;

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  sit_diff u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .seg_i   (seg_i),
    .valid_o (s1_valid),
    .diff_o  (s1_diff)
  );

  sit_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .diff_i  (s1_diff),
    .valid_o (s2_valid),
    .prod_o  (s2_prod)
  );

  sit_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .prod_i  (s2_prod),
    .valid_o (s3_valid),
    .num_o   (s3_num)
  );

  sit_decide u_decide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .num_i   (s3_num),
    .valid_o (done_o),
    .res_o   (res_o)
  );

  `SIT_ASSERT(a_done_follows_start, clk_i, rst_ni, done_o |-> $past(start, 4))
  `SIT_ASSERT(a_start_gives_done, clk_i, rst_ni, (start && $past(rst_ni, 1)) |-> ##4 done_o)

endmodule
`default_nettype wire

// ===== test/tb_segment_intersection_test.sv =====
// Testbench for the segment intersection test block: directed and random segment pairs
`timescale 1ns / 1ps
module tb_segment_intersection_test;
  import sit_pkg::*;

  localparam int RandomPairs   = 500;
  localparam int QuietPairs    = 100;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;
  localparam int PrintLimit    = 40;

  // Expected-result store and exact integer predictor for the intersection test
  class intersect_scoreboard;
    sit_out_t expected_q[$];
    int       errors;

    function longint coord(logic [FieldW-1:0] f);
      logic signed [CoordWidth-1:0] c;
      c = f[CoordWidth-1:0];
      return longint'(c);
    endfunction

    function bit spans(longint p, longint e0, longint e1);
      longint lo, hi;
      lo = (e0 < e1) ? e0 : e1;
      hi = (e0 < e1) ? e1 : e0;
      return (p >= lo) && (p <= hi);
    endfunction

    function bit in_box(longint px, longint py, longint x0, longint y0,
                        longint x1, longint y1);
      return spans(px, x0, x1) && spans(py, y0, y1);
    endfunction

    // num/den in [0,1] without dividing; den is nonzero here
    function bit unit_ratio(longint num, longint den);
      if (den > 0) return (num >= 0) && (num <= den);
      return (num <= 0) && (num >= den);
    endfunction

    function sit_out_t predict_hit(sit_in_t p);
      longint x1, y1, x2, y2, x3, y3, x4, y4, na, nb, dn;
      sit_out_t r;
      x1 = coord(p.ax0); y1 = coord(p.ay0);
      x2 = coord(p.ax1); y2 = coord(p.ay1);
      x3 = coord(p.bx0); y3 = coord(p.by0);
      x4 = coord(p.bx1); y4 = coord(p.by1);
      na = (x4 - x3) * (y1 - y3) - (y4 - y3) * (x1 - x3);
      nb = (x2 - x1) * (y1 - y3) - (y2 - y1) * (x1 - x3);
      dn = (y4 - y3) * (x2 - x1) - (x4 - x3) * (y2 - y1);
      r.hit = 1'b0;
      if (dn == 0 && na == 0 && nb == 0) begin
        r.relation = RelCollinear;
        // check the endpoints of both segments against the other's box
        r.hit = in_box(x1, y1, x3, y3, x4, y4) || in_box(x2, y2, x3, y3, x4, y4) ||
                in_box(x3, y3, x1, y1, x2, y2) || in_box(x4, y4, x1, y1, x2, y2);
      end else if (dn == 0) begin
        r.relation = RelParallel;
      end else begin
        r.relation = RelCross;
        r.hit = unit_ratio(na, dn) && unit_ratio(nb, dn);
      end
      return r;
    endfunction

    function void note_pair(sit_in_t p);
      expected_q.push_back(predict_hit(p));
    endfunction

    task report_error(string msg);
      if (errors < PrintLimit) $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(sit_out_t got);
      sit_out_t want;
      if (expected_q.size() == 0) begin
        report_error("result beat with no pending segment pair");
      end else begin
        want = expected_q.pop_front();
        if (got.hit !== want.hit)
          report_error($sformatf("hit got %0b want %0b", got.hit, want.hit));
        if (got.relation !== want.relation)
          report_error($sformatf("relation got %0d want %0d", got.relation, want.relation));
      end
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  sit_in_t   seg_i;
  logic      busy;
  logic      done_o;
  sit_out_t  res_o;

  intersect_scoreboard sb = new();
  int  quiet_cycles = 0;
  bit  gaps_on;

  segment_intersection_test dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .seg_i  (seg_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Take accepted beats in both directions and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_pair(seg_i);
    if (rst_ni && done_o) sb.check_result(res_o);
    if ((rst_ni && start && !busy) || (rst_ni && done_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic sit_in_t pair_of(int x0, int y0, int x1, int y1,
                                      int u0, int v0, int u1, int v1);
    sit_in_t p;
    p.ax0 = x0[FieldW-1:0]; p.ay0 = y0[FieldW-1:0];
    p.ax1 = x1[FieldW-1:0]; p.ay1 = y1[FieldW-1:0];
    p.bx0 = u0[FieldW-1:0]; p.by0 = v0[FieldW-1:0];
    p.bx1 = u1[FieldW-1:0]; p.by1 = v1[FieldW-1:0];
    return p;
  endfunction

  // Drive one pair from a falling edge and hold it until a rising edge takes it
  task automatic send_pair(input sit_in_t p);
    int gap;
    gap = (gaps_on && $urandom_range(0, 2) == 0) ? int'($urandom_range(1, 7)) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      seg_i <= sit_in_t'({$urandom, $urandom, $urandom, $urandom});
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    seg_i <= p;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic sit_in_t random_pair();
    int px, py, dx, dy, m;
    sit_in_t p;
    case ($urandom_range(0, 9))
      0, 1, 2: p = sit_in_t'({$urandom, $urandom, $urandom, $urandom});
      3, 4: p = pair_of(pick(-12, 12), pick(-12, 12), pick(-12, 12), pick(-12, 12),
                        pick(-12, 12), pick(-12, 12), pick(-12, 12), pick(-12, 12));
      5, 6: begin
        // four points on one lattice line
        px = pick(-30000, 30000); py = pick(-30000, 30000);
        dx = pick(-40, 40);       dy = pick(-40, 40);
        p = pair_of(px + pick(-25, 25) * dx, 0, px + pick(-25, 25) * dx, 0, 0, 0, 0, 0);
        m = pick(-25, 25); p.ax0 = FieldW'(px + m * dx); p.ay0 = FieldW'(py + m * dy);
        m = pick(-25, 25); p.ax1 = FieldW'(px + m * dx); p.ay1 = FieldW'(py + m * dy);
        m = pick(-25, 25); p.bx0 = FieldW'(px + m * dx); p.by0 = FieldW'(py + m * dy);
        m = pick(-25, 25); p.bx1 = FieldW'(px + m * dx); p.by1 = FieldW'(py + m * dy);
      end
      7: begin
        px = pick(-1000, 1000); py = pick(-1000, 1000);
        dx = pick(-500, 500);   dy = pick(-500, 500);
        m = pick(-20, 20);      m = (m == 0) ? 1 : m;
        p = pair_of(px, py, px + dx, py + dy, px + m, py - pick(-20, 20),
                    px + m + dx, py + dy);
        p.by0 = FieldW'(p.by1 - dy);
      end
      default: begin
        // one end of the second segment lies on the first: at an end or inside it
        px = pick(-2000, 2000); py = pick(-2000, 2000);
        dx = pick(-300, 300);   dy = pick(-300, 300);
        m = pick(0, 4);
        p = pair_of(px, py, px + 4 * dx, py + 4 * dy, px + m * dx, py + m * dy,
                    pick(-3000, 3000), pick(-3000, 3000));
        if ($urandom_range(0, 1)) p = {p.ax0, p.ay0, p.ax1, p.ay1, p.bx1, p.by1, p.bx0, p.by0};
      end
    endcase
    return p;
  endfunction

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    seg_i = '0;
    gaps_on = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, each relation, end touches, degenerate segments
    send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(pair_of(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    send_pair(pair_of(0, 0, 10, 0, 20, -5, 20, 5));
    send_pair(pair_of(0, 0, 10, 0, 10, 0, 10, 10));
    send_pair(pair_of(0, 0, 10, 0, 0, -5, 0, 5));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 9));
    send_pair(pair_of(0, 0, 10, 0, 0, 1, 10, 1));
    send_pair(pair_of(0, 0, 10, 10, 5, 5, 20, 20));
    send_pair(pair_of(0, 0, 4, 4, 5, 5, 9, 9));
    send_pair(pair_of(0, 0, 5, 5, 5, 5, 9, 9));
    send_pair(pair_of(3, 3, 4, 4, 0, 0, 10, 10));
    send_pair(pair_of(0, 0, 10, 10, 3, 3, 4, 4));
    send_pair(pair_of(0, 0, 10, 0, 5, 5, 5, 5));
    send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 0));
    send_pair(pair_of(5, 5, 5, 5, 0, 0, 10, 0));
    send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
    send_pair(pair_of(-32768, 32767, 32767, 32767, 0, -32768, 0, 32766));
    send_pair(pair_of(-32768, 0, 32767, 0, 32767, 0, -32768, 0));
    send_pair(pair_of(0, -32768, 0, -1, 0, 0, 0, 32767));
    send_pair(pair_of(-1, -1, -1, -1, -1, -1, 0, 0));

    for (int i = 0; i < RandomPairs; i++) begin
      // bursts of idling, with idle-free stretches and a quiet tail
      gaps_on = (i < RandomPairs - QuietPairs) && ((i % 100) < 70);
      send_pair(random_pair());
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
